FILE: src/assert_macros.svh
// Assertion helpers used by work_stealing_task_queues.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: src/wstq_pkg.sv
package wstq_pkg;

   localparam int ID_W       = 6;
   localparam int CNT_W      = 7;
   localparam int CAP_REG_W  = 11;
   localparam int NUM_W      = 31;
   localparam int TASK_W     = 2 * NUM_W;
   localparam int STATUS_W   = 3;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 11;
   localparam int SCAN_LANES = 8;

   localparam logic [1:0] OP_ADD   = 2'd0;
   localparam logic [1:0] OP_GET   = 2'd1;
   localparam logic [1:0] OP_STEAL = 2'd2;
   localparam logic [1:0] OP_NONE  = 2'd3;

   localparam logic [STATUS_W-1:0] ST_ADDED  = 3'd0;
   localparam logic [STATUS_W-1:0] ST_FULL   = 3'd1;
   localparam logic [STATUS_W-1:0] ST_BADID  = 3'd2;
   localparam logic [STATUS_W-1:0] ST_NONE   = 3'd3;
   localparam logic [STATUS_W-1:0] ST_LOCAL  = 3'd4;
   localparam logic [STATUS_W-1:0] ST_STOLEN = 3'd5;

   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_CAPACITY = 1'b1;

   typedef struct packed {
      logic [1:0]       req_type;
      logic [ID_W-1:0]  owner_id;
      logic [ID_W-1:0]  target_id;
      logic [NUM_W-1:0] task_start;
      logic [NUM_W-1:0] task_end;
   } req_item_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [NUM_W-1:0]    out_start;
      logic [NUM_W-1:0]    out_end;
      logic [ID_W-1:0]     source_worker;
   } rsp_item_type;

   typedef struct packed {
      logic            found;
      logic            more;
      logic [ID_W-1:0] idx;
   } scan_res_type;

endpackage

FILE: src/wstq_scan.sv
module wstq_scan #(
   parameter int MAX_WORKERS = 64
) (
   input  logic [MAX_WORKERS-1:0]       flags,
   input  logic [wstq_pkg::ID_W-1:0]    worker,
   input  logic [wstq_pkg::CNT_W-1:0]   eff_n,
   input  logic [wstq_pkg::CNT_W-1:0]   offset,
   output wstq_pkg::scan_res_type       res
);
   import wstq_pkg::*;

   localparam int WID_W = $clog2(MAX_WORKERS);

   // Each lane checks one queue of the round-robin order; the lowest lane that hits wins.
   always_comb begin
      logic [7:0] pos;
      logic [7:0] cand;
      logic [7:0] n8;
      logic       lane_ok;
      res = '0;
      n8 = 8'(eff_n);
      for (int k = SCAN_LANES - 1; k >= 0; k--) begin
         pos = 8'(offset) + 8'(k);
         lane_ok = (pos + 8'd1) < n8;
         cand = 8'(worker) + 8'd1 + pos;
         if (cand >= n8) begin
            cand = cand - n8;
         end
         if (lane_ok && flags[cand[WID_W-1:0]]) begin
            res.found = 1'b1;
            res.idx = ID_W'(cand[WID_W-1:0]);
         end
      end
      res.more = (8'(offset) + 8'(SCAN_LANES) + 8'd1) < n8;
   end

endmodule

FILE: src/work_stealing_task_queues.sv
// From decode to the response strobe: requests settled at decode respond from decode, add goes
// through the pointer state, local pop and named steal through the pointer and task states, and
// a get-work steal scans the other queues in groups of eight, then takes the pointer and task
// states if it finds a task or responds from the scan if not. Busy drops in the strobe cycle,
// so the next request is accepted at the edge that ends it; the receiver cannot stall. Synchronous
// reset sets 64 workers and ring size 1024 and empties every queue at once via per-queue valid bits.
`include "assert_macros.svh"

module work_stealing_task_queues #(
   parameter int MAX_WORKERS = 64,
   parameter int QUEUE_DEPTH = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  wstq_pkg::req_item_type            req_item,
   output logic                              rsp_strobe,
   output wstq_pkg::rsp_item_type            rsp_item,
   input  logic                              csr_we,
   input  logic [wstq_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [wstq_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import wstq_pkg::*;

   localparam int WID_W      = $clog2(MAX_WORKERS);
   localparam int PTR_W      = $clog2(QUEUE_DEPTH);
   localparam int EC_W       = ($clog2(QUEUE_DEPTH + 1) > CAP_REG_W) ?
                               $clog2(QUEUE_DEPTH + 1) : CAP_REG_W;
   localparam int TASK_DEPTH = MAX_WORKERS * (1 << PTR_W);
   localparam int TADDR_W    = WID_W + PTR_W;

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_DECODE = 5'b00010,
      S_SCAN   = 5'b00100,
      S_PTR    = 5'b01000,
      S_TASK   = 5'b10000
   } state_type;

   state_type              state_ff, state_in;
   req_item_type           req_ff, req_in;
   logic [WID_W-1:0]       tgt_ff, tgt_in;
   logic                   steal_ff, steal_in;
   logic [CNT_W-1:0]       off_ff, off_in;
   logic [CNT_W-1:0]       active_ff, active_in;
   logic [CAP_REG_W-1:0]   cap_ff, cap_in;
   logic [MAX_WORKERS-1:0] vld_ff, vld_in;
   logic [MAX_WORKERS-1:0] nonempty_ff, nonempty_in;
   rsp_item_type           rsp_ff, rsp_in;
   logic                   rsp_strobe_ff, rsp_strobe_in;

   logic [2*PTR_W-1:0]     ptr_mem [MAX_WORKERS];
   logic [2*PTR_W-1:0]     ptr_rd_ff;
   logic                   ptr_vld_rd_ff;
   logic                   ptr_we;
   logic [2*PTR_W-1:0]     ptr_wdata;

   logic [TASK_W-1:0]      task_mem [TASK_DEPTH];
   logic [TASK_W-1:0]      task_rd_ff;
   logic                   task_we;
   logic [TADDR_W-1:0]     task_waddr;
   logic [TADDR_W-1:0]     task_raddr;

   logic [CNT_W-1:0]       eff_n;
   logic [EC_W-1:0]        eff_cap;
   logic [PTR_W-1:0]       ptr_h, ptr_t, h_inc, t_inc, t_dec;
   logic [WID_W-1:0]       w_idx, v_idx;
   scan_res_type           scan_res;

   wstq_scan #(
      .MAX_WORKERS(MAX_WORKERS)
   ) u_scan (
      .flags (nonempty_ff),
      .worker(req_ff.owner_id),
      .eff_n (eff_n),
      .offset(off_ff),
      .res   (scan_res)
   );

   always_comb begin
      eff_n = active_ff;
      if (active_ff == '0) begin
         eff_n = CNT_W'(1);
      end else if (active_ff > CNT_W'(MAX_WORKERS)) begin
         eff_n = CNT_W'(MAX_WORKERS);
      end
      eff_cap = EC_W'(cap_ff);
      if (eff_cap < EC_W'(2)) begin
         eff_cap = EC_W'(2);
      end else if (eff_cap > EC_W'(QUEUE_DEPTH)) begin
         eff_cap = EC_W'(QUEUE_DEPTH);
      end
   end

   assign ptr_h = ptr_vld_rd_ff ? ptr_rd_ff[2*PTR_W-1:PTR_W] : '0;
   assign ptr_t = ptr_vld_rd_ff ? ptr_rd_ff[PTR_W-1:0] : '0;
   assign h_inc = ((EC_W'(ptr_h) + EC_W'(1)) >= eff_cap) ? '0 : ptr_h + PTR_W'(1);
   assign t_inc = ((EC_W'(ptr_t) + EC_W'(1)) >= eff_cap) ? '0 : ptr_t + PTR_W'(1);
   assign t_dec = (ptr_t == '0) ? PTR_W'(eff_cap - EC_W'(1)) : ptr_t - PTR_W'(1);
   assign w_idx = req_ff.owner_id[WID_W-1:0];
   assign v_idx = req_ff.target_id[WID_W-1:0];
   assign task_waddr = {tgt_ff, ptr_t};
   assign task_raddr = steal_ff ? {tgt_ff, t_dec} : {tgt_ff, ptr_h};

   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      tgt_in        = tgt_ff;
      steal_in      = steal_ff;
      off_in        = off_ff;
      active_in     = active_ff;
      cap_in        = cap_ff;
      vld_in        = vld_ff;
      nonempty_in   = nonempty_ff;
      rsp_in        = rsp_ff;
      rsp_strobe_in = 1'b0;
      ptr_we        = 1'b0;
      ptr_wdata     = {ptr_h, ptr_t};
      task_we       = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (csr_we) begin
               case (csr_index)
                  CSR_ACTIVE:   active_in = csr_wdata[CNT_W-1:0];
                  CSR_CAPACITY: cap_in = csr_wdata[CAP_REG_W-1:0];
                  default:      cap_in = cap_ff;
               endcase
               vld_in = '0;
               nonempty_in = '0;
            end
            if (start) begin
               req_in = req_item;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            rsp_in = '0;
            steal_in = 1'b0;
            off_in = '0;
            state_in = S_IDLE;
            if (req_ff.req_type == OP_NONE) begin
               rsp_in.status = ST_NONE;
               rsp_strobe_in = 1'b1;
            end else if (CNT_W'(req_ff.owner_id) >= eff_n) begin
               rsp_in.status = ST_BADID;
               rsp_strobe_in = 1'b1;
            end else if (req_ff.req_type == OP_ADD) begin
               tgt_in = w_idx;
               state_in = S_PTR;
            end else if (req_ff.req_type == OP_GET) begin
               if (nonempty_ff[w_idx]) begin
                  tgt_in = w_idx;
                  state_in = S_PTR;
               end else begin
                  state_in = S_SCAN;
               end
            end else if (CNT_W'(req_ff.target_id) >= eff_n) begin
               rsp_in.status = ST_BADID;
               rsp_strobe_in = 1'b1;
            end else if (req_ff.target_id == req_ff.owner_id || !nonempty_ff[v_idx]) begin
               rsp_in.status = ST_NONE;
               rsp_strobe_in = 1'b1;
            end else begin
               tgt_in = v_idx;
               steal_in = 1'b1;
               state_in = S_PTR;
            end
         end
         S_SCAN: begin
            if (scan_res.found) begin
               tgt_in = scan_res.idx[WID_W-1:0];
               steal_in = 1'b1;
               state_in = S_PTR;
            end else if (scan_res.more) begin
               off_in = off_ff + CNT_W'(SCAN_LANES);
            end else begin
               rsp_in = '0;
               rsp_in.status = ST_NONE;
               rsp_strobe_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_PTR: begin
            if (req_ff.req_type == OP_ADD) begin
               state_in = S_IDLE;
               rsp_in = '0;
               rsp_strobe_in = 1'b1;
               if (t_inc == ptr_h) begin
                  rsp_in.status = ST_FULL;
               end else begin
                  rsp_in.status = ST_ADDED;
                  task_we = 1'b1;
                  ptr_we = 1'b1;
                  ptr_wdata = {ptr_h, t_inc};
                  vld_in[tgt_ff] = 1'b1;
                  nonempty_in[tgt_ff] = 1'b1;
               end
            end else if (steal_ff) begin
               ptr_we = 1'b1;
               ptr_wdata = {ptr_h, t_dec};
               vld_in[tgt_ff] = 1'b1;
               nonempty_in[tgt_ff] = (ptr_h != t_dec);
               state_in = S_TASK;
            end else begin
               ptr_we = 1'b1;
               ptr_wdata = {h_inc, ptr_t};
               vld_in[tgt_ff] = 1'b1;
               nonempty_in[tgt_ff] = (h_inc != ptr_t);
               state_in = S_TASK;
            end
         end
         S_TASK: begin
            rsp_in.status = steal_ff ? ST_STOLEN : ST_LOCAL;
            rsp_in.out_start = task_rd_ff[NUM_W-1:0];
            rsp_in.out_end = task_rd_ff[TASK_W-1:NUM_W];
            rsp_in.source_worker = ID_W'(tgt_ff);
            rsp_strobe_in = 1'b1;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         active_ff     <= CNT_W'(64);
         cap_ff        <= CAP_REG_W'(1024);
         vld_ff        <= '0;
         nonempty_ff   <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         active_ff     <= active_in;
         cap_ff        <= cap_in;
         vld_ff        <= vld_in;
         nonempty_ff   <= nonempty_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff   <= req_in;
      tgt_ff   <= tgt_in;
      steal_ff <= steal_in;
      off_ff   <= off_in;
      rsp_ff   <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (ptr_we) begin
         ptr_mem[tgt_ff] <= ptr_wdata;
      end
      ptr_rd_ff     <= ptr_mem[tgt_in];
      ptr_vld_rd_ff <= vld_ff[tgt_in];
   end

   always_ff @(posedge clock) begin
      if (task_we) begin
         task_mem[task_waddr] <= {req_ff.task_end, req_ff.task_start};
      end
      task_rd_ff <= task_mem[task_raddr];
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

   `ASSERT_NEXT(a_no_early_rsp, clock, reset, start && !busy, !rsp_strobe)
   `ASSERT_IMPLIES(a_rsp_when_idle, clock, reset, rsp_strobe, !busy)
   `ASSERT_IMPLIES(a_flag_match, clock, reset, state_ff == S_PTR,
                   nonempty_ff[tgt_ff] == (ptr_h != ptr_t))
   `ASSERT_IMPLIES(a_empty_payload, clock, reset,
                   rsp_strobe && rsp_item.status != ST_LOCAL && rsp_item.status != ST_STOLEN,
                   rsp_item.out_start == '0 && rsp_item.out_end == '0 &&
                   rsp_item.source_worker == '0)

endmodule

FILE: tb/work_stealing_task_queues_test.sv
`default_nettype none

module work_stealing_task_queues_test;
   timeunit 1ns;
   timeprecision 1ps;

   import wstq_pkg::*;

   localparam int WORKER_LIMIT  = 64;
   localparam int RING_SLOTS    = 1024;
   localparam int PTR_W         = 10;
   localparam int SETTLE_CYCLES = 6;

   typedef enum logic [1:0] {
      ENTRY_REQ,
      ENTRY_CSR,
      ENTRY_WAIT
   } entry_kind_type;

   typedef struct packed {
      entry_kind_type              kind;
      req_item_type                item;
      logic [CSR_IDX_W-1:0]        csr_idx;
      logic [CSR_DATA_W-1:0]       csr_data;
   } stim_entry_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    start = 1'b0;
   logic                    busy;
   req_item_type            req_item = '0;
   logic                    rsp_strobe;
   rsp_item_type            rsp_item;
   logic                    csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]    csr_index = '0;
   logic [CSR_DATA_W-1:0]   csr_wdata = '0;

   stim_entry_type          pending[$];
   rsp_item_type            due_responses[$];
   logic                    req_taken = 1'b0;
   logic                    stim_exhausted = 1'b0;
   int                      fail_count = 0;
   int                      burst_left = 0;
   int                      gap_left = 0;
   int                      settle_count = 0;
   int                      gen_workers = WORKER_LIMIT;

   logic [CNT_W-1:0]        active_raw;
   logic [CAP_REG_W-1:0]    capacity_raw;
   logic [PTR_W-1:0]        q_head [WORKER_LIMIT];
   logic [PTR_W-1:0]        q_tail [WORKER_LIMIT];
   logic [TASK_W-1:0]       task_mem [WORKER_LIMIT * RING_SLOTS];

   work_stealing_task_queues u_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic logic [TASK_W-1:0] take_newest(int unsigned vic, int unsigned cap);
      int unsigned t;
      t = q_tail[vic];
      t = (t == 0) ? cap - 1 : t - 1;
      q_tail[vic] = PTR_W'(t);
      return task_mem[vic * RING_SLOTS + t];
   endfunction

   function automatic rsp_item_type dispatch_outcome(req_item_type r);
      rsp_item_type      res;
      int unsigned       n;
      int unsigned       cap;
      int unsigned       w;
      int unsigned       v;
      int unsigned       vic;
      int unsigned       t;
      logic [TASK_W-1:0] tsk;
      bit                found;
      res   = '0;
      found = 1'b0;
      tsk   = '0;
      vic   = 0;
      n     = (active_raw == 0) ? 1 : ((active_raw > WORKER_LIMIT) ? WORKER_LIMIT : active_raw);
      cap   = (capacity_raw < 2) ? 2 : ((capacity_raw > RING_SLOTS) ? RING_SLOTS : capacity_raw);
      w     = r.owner_id;
      v     = r.target_id;
      if (r.req_type == OP_NONE) begin
         res.status = ST_NONE;
      end else if (w >= n) begin
         res.status = ST_BADID;
      end else if (r.req_type == OP_ADD) begin
         t = q_tail[w];
         t = (t + 1 >= cap) ? 0 : t + 1;
         if (t == q_head[w]) begin
            res.status = ST_FULL;
         end else begin
            task_mem[w * RING_SLOTS + q_tail[w]] = {r.task_end, r.task_start};
            q_tail[w] = PTR_W'(t);
            res.status = ST_ADDED;
         end
      end else if (r.req_type == OP_GET) begin
         if (q_head[w] != q_tail[w]) begin
            t = q_head[w];
            tsk = task_mem[w * RING_SLOTS + t];
            q_head[w] = PTR_W'((t + 1 >= cap) ? 0 : t + 1);
            res.status = ST_LOCAL;
            vic = w;
            found = 1'b1;
         end else begin
            res.status = ST_NONE;
            for (int a = 1; a < n; a++) begin
               t = (w + a) % n;
               if (!found && q_head[t] != q_tail[t]) begin
                  found = 1'b1;
                  vic = t;
                  tsk = take_newest(t, cap);
                  res.status = ST_STOLEN;
               end
            end
         end
      end else begin
         if (v >= n) begin
            res.status = ST_BADID;
         end else if (v == w || q_head[v] == q_tail[v]) begin
            res.status = ST_NONE;
         end else begin
            tsk = take_newest(v, cap);
            res.status = ST_STOLEN;
            vic = v;
            found = 1'b1;
         end
      end
      if (found) begin
         res.out_start     = tsk[NUM_W-1:0];
         res.out_end       = tsk[TASK_W-1:NUM_W];
         res.source_worker = ID_W'(vic);
      end
      return res;
   endfunction

   task automatic push_request(input logic [1:0] op, input int w, input int v,
                               input logic [NUM_W-1:0] ts, input logic [NUM_W-1:0] te);
      stim_entry_type e;
      e = '0;
      e.kind = ENTRY_REQ;
      e.item.req_type   = op;
      e.item.owner_id   = ID_W'(w);
      e.item.target_id  = ID_W'(v);
      e.item.task_start = ts;
      e.item.task_end   = te;
      pending.push_back(e);
   endtask

   task automatic push_pause();
      stim_entry_type e;
      e = '0;
      e.kind = ENTRY_WAIT;
      pending.push_back(e);
   endtask

   task automatic push_config(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      stim_entry_type e;
      int             n;
      e = '0;
      e.kind     = ENTRY_CSR;
      e.csr_idx  = idx;
      e.csr_data = data;
      pending.push_back(e);
      if (idx == CSR_ACTIVE) begin
         n = data[CNT_W-1:0];
         gen_workers = (n == 0) ? 1 : ((n > WORKER_LIMIT) ? WORKER_LIMIT : n);
      end
   endtask

   task automatic queue_random_phase(input logic [CSR_DATA_W-1:0] workers_data,
                                     input logic [CSR_DATA_W-1:0] ring_data,
                                     input int count, input int add_pct, input bit ring_first);
      int         roll;
      int         w;
      int         v;
      logic [1:0] op;
      push_pause();
      if (ring_first) begin
         push_config(CSR_CAPACITY, ring_data);
         push_config(CSR_ACTIVE, workers_data);
      end else begin
         push_config(CSR_ACTIVE, workers_data);
         push_config(CSR_CAPACITY, ring_data);
      end
      for (int i = 0; i < count; i++) begin
         if (i == count / 2) begin
            push_pause();
         end
         roll = $urandom_range(0, 99);
         if (roll < add_pct) begin
            op = OP_ADD;
         end else if (roll < add_pct + 30) begin
            op = OP_GET;
         end else if (roll < 97) begin
            op = OP_STEAL;
         end else begin
            op = OP_NONE;
         end
         w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63)
                                         : $urandom_range(0, gen_workers - 1);
         v = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63)
                                         : $urandom_range(0, gen_workers - 1);
         push_request(op, w, v, NUM_W'($urandom()), NUM_W'($urandom()));
      end
   endtask

   // Requests are issued in bursts; a pause entry holds off until every response is back.
   always @(negedge clock) begin : driver
      stim_entry_type head_entry;
      logic           drive_start;
      logic           drive_we;
      drive_start = start && !req_taken;
      drive_we    = 1'b0;
      if (!reset && !drive_start) begin
         if (gap_left != 0) begin
            gap_left--;
         end else if (pending.size() != 0) begin
            head_entry = pending[0];
            case (head_entry.kind)
               ENTRY_REQ: begin
                  req_item <= head_entry.item;
                  drive_start = 1'b1;
                  void'(pending.pop_front());
                  if (burst_left > 0) begin
                     burst_left--;
                  end else begin
                     burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                              : $urandom_range(1, 12);
                     gap_left   = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 30)
                                                              : $urandom_range(1, 5);
                  end
               end
               ENTRY_CSR: begin
                  drive_we = 1'b1;
                  csr_index <= head_entry.csr_idx;
                  csr_wdata <= head_entry.csr_data;
                  if (head_entry.csr_idx == CSR_ACTIVE) begin
                     active_raw = head_entry.csr_data[CNT_W-1:0];
                  end else begin
                     capacity_raw = head_entry.csr_data;
                  end
                  for (int i = 0; i < WORKER_LIMIT; i++) begin
                     q_head[i] = '0;
                     q_tail[i] = '0;
                  end
                  void'(pending.pop_front());
               end
               default: begin
                  if (due_responses.size() != 0) begin
                     settle_count = 0;
                  end else if (settle_count < SETTLE_CYCLES) begin
                     settle_count++;
                  end else begin
                     settle_count = 0;
                     void'(pending.pop_front());
                  end
               end
            endcase
         end else begin
            stim_exhausted <= 1'b1;
         end
      end
      start  <= drive_start;
      csr_we <= drive_we;
   end

   always @(posedge clock) begin : monitor
      rsp_item_type want;
      req_taken = !reset && start && !busy;
      if (!reset && rsp_strobe) begin
         if (due_responses.size() == 0) begin
            $error("response with no request outstanding: %p", rsp_item);
            fail_count++;
         end else begin
            want = due_responses.pop_front();
            if (rsp_item.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_item.status);
               fail_count++;
            end
            if (rsp_item.out_start !== want.out_start) begin
               $error("out_start: expected %0d, got %0d", want.out_start, rsp_item.out_start);
               fail_count++;
            end
            if (rsp_item.out_end !== want.out_end) begin
               $error("out_end: expected %0d, got %0d", want.out_end, rsp_item.out_end);
               fail_count++;
            end
            if (rsp_item.source_worker !== want.source_worker) begin
               $error("source_worker: expected %0d, got %0d", want.source_worker,
                      rsp_item.source_worker);
               fail_count++;
            end
         end
      end
      if (req_taken) begin
         due_responses.push_back(dispatch_outcome(req_item));
      end
   end

   initial begin
      #1_000_000;
      $display("FAILURE");
      $finish;
   end

   initial begin
      active_raw   = CNT_W'(WORKER_LIMIT);
      capacity_raw = CAP_REG_W'(RING_SLOTS);
      for (int i = 0; i < WORKER_LIMIT; i++) begin
         q_head[i] = '0;
         q_tail[i] = '0;
      end

      // Full width of workers and ring size, as after reset.
      push_request(OP_NONE, 63, 63, '1, '1);
      push_request(OP_ADD, 0, 0, 31'h7FFF_FFFF, '0);
      push_request(OP_ADD, 0, 63, '0, 31'h7FFF_FFFF);
      push_request(OP_ADD, 0, 0, 31'd5, 31'd6);
      push_request(OP_GET, 0, 0, '0, '0);
      push_request(OP_GET, 5, 0, '0, '0);
      push_request(OP_STEAL, 1, 0, '0, '0);
      push_request(OP_GET, 63, 0, '0, '0);
      push_request(OP_ADD, 63, 0, 31'h1234_5678, 31'h2345_6789);
      push_request(OP_GET, 62, 0, '0, '0);
      push_request(OP_ADD, 3, 0, 31'h5555_5555, 31'h2AAA_AAAA);
      push_request(OP_STEAL, 3, 3, '0, '0);
      push_request(OP_STEAL, 2, 3, '0, '0);
      push_request(OP_STEAL, 2, 3, '0, '0);

      // One worker with the smallest ring.
      push_pause();
      push_config(CSR_ACTIVE, 11'd1);
      push_config(CSR_CAPACITY, 11'd2);
      push_request(OP_ADD, 0, 0, 31'd7, 31'd9);
      push_request(OP_ADD, 0, 0, 31'd8, 31'd10);
      push_request(OP_GET, 0, 0, '0, '0);
      push_request(OP_GET, 0, 0, '0, '0);
      push_request(OP_ADD, 1, 0, 31'd1, 31'd2);
      push_request(OP_STEAL, 0, 1, '0, '0);
      push_request(OP_STEAL, 0, 0, '0, '0);
      push_request(OP_NONE, 5, 9, '0, '0);
      push_request(OP_GET, 63, 0, '0, '0);

      queue_random_phase(11'h000, 11'h001, 60, 50, 1'b0);
      queue_random_phase(11'd3, 11'd4, 110, 50, 1'b1);
      queue_random_phase(11'h7FF, 11'h7FF, 120, 55, 1'b1);
      queue_random_phase(11'd2, 11'd1024, 100, 60, 1'b0);
      queue_random_phase(11'd64, 11'd5, 110, 50, 1'b0);
      queue_random_phase(11'd8, 11'd16, 120, 55, 1'b1);
      queue_random_phase(11'h421, 11'd3, 110, 45, 1'b0);
      queue_random_phase(11'd5, 11'd1000, 120, 50, 1'b1);
      queue_random_phase(11'd64, 11'd1024, 60, 45, 1'b0);
      push_pause();

      repeat (5) @(negedge clock);
      reset <= 1'b0;

      wait (stim_exhausted);
      repeat (20) @(posedge clock);
      if (due_responses.size() != 0) begin
         $error("%0d responses never arrived", due_responses.size());
         fail_count++;
      end
      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

`default_nettype wire
